/* sv/dld_pkg.sv */
// Shared types, codes and constants of the daylight LED dimmer.
package dld_pkg;

    // Curve and day-triangle constants.
    localparam logic [7:0]  FULL_LEVEL      = 8'd250;
    localparam logic [7:0]  QUARTER_LEVEL   = 8'd62;
    localparam logic [7:0]  DUTY_MAX        = 8'd187;
    localparam logic [9:0]  STEP_LEVEL      = 10'd83;
    localparam logic [9:0]  DAY_LEVEL_SCALE = 10'd500;
    localparam logic [6:0]  PCT_MAX         = 7'd100;
    localparam logic [16:0] DAY_SECONDS     = 17'd86400;
    localparam logic [16:0] HALF_DAY        = 17'd43200;

    // Shared divider widths.
    localparam int DIV_W  = 32;
    localparam int DSOR_W = 17;

    // Operation codes of an input request.
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_RGB   = 3'd3,
        OP_WHITE = 3'd4,
        OP_SYNC  = 3'd5,
        OP_HOLD  = 3'd6
    } t_op;

    // Light mode codes.
    typedef enum logic [1:0] {
        MODE_SYNC = 2'd0,
        MODE_HOLD = 2'd1,
        MODE_CMD  = 2'd2
    } t_mode;

    // Fixed divisors that the shared divider serves.
    typedef enum logic [1:0] {
        DIV_DAY   = 2'd0,
        DIV_PCT   = 2'd1,
        DIV_FULL  = 2'd2,
        DIV_THIRD = 2'd3
    } t_div_sel;

    // Channel indexes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_WHITE = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  channel;
        logic [6:0]  percent;
        logic [31:0] epoch_seconds;
    } t_in_item;

    typedef struct packed {
        logic [7:0] duty_red;
        logic [7:0] duty_green;
        logic [7:0] duty_blue;
        logic [7:0] duty_white;
        logic [1:0] light_state;
    } t_out_item;

    // Request and response of the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        t_div_sel          divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DSOR_W-1:0] remainder;
    } t_div_rsp;

endpackage

/* sv/dld_stream_if.sv */
// Valid/ready channel interfaces of the daylight LED dimmer.
interface dld_in_if;
    import dld_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dld_out_if;
    import dld_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/dld_div.sv */
// Divider by the dimmer's fixed divisors, by reciprocal multiplication.
module dld_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dld_pkg::t_div_req i_req,
    output dld_pkg::t_div_rsp o_rsp
);
    import dld_pkg::*;

    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int QUO_W  = 16;

    // Reciprocals, rounded up. The quotient is exact for any 32-bit dividend over the
    // day, up to 31750 for the percent scale, up to 62500 over full level and up to
    // 250 for the third.
    localparam logic [MUL_W-1:0] RCP_DAY   = 26'd50903317;  // 2^35 / 675, after a shift by 7
    localparam logic [MUL_W-1:0] RCP_PCT   = 26'd20972;     // 2^21 / 100
    localparam logic [MUL_W-1:0] RCP_FULL  = 26'd67109;     // 2^24 / 250
    localparam logic [MUL_W-1:0] RCP_THIRD = 26'd171;       // 2^9 / 3

    typedef enum logic [1:0] {
        D_IDLE,
        D_RECIP,
        D_BACK
    } t_div_state;

    t_div_state        r_dstate;
    logic              r_done;
    t_div_sel          r_sel;
    logic [DIV_W-1:0]  r_dvd;
    logic [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]  r_quo;
    logic [DSOR_W-1:0] r_rem;

    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] product;
    logic [QUO_W-1:0]  quo_est;

    // Quotient taken from the registered reciprocal product.
    always_comb begin
        unique case (r_sel)
            DIV_DAY:   quo_est = r_prod[50:35];
            DIV_PCT:   quo_est = r_prod[36:21];
            DIV_FULL:  quo_est = r_prod[39:24];
            DIV_THIRD: quo_est = r_prod[24:9];
            default:   quo_est = '0;
        endcase
    end

    // Operands of the one multiplier: the reciprocal first, then the divisor back
    // out of the quotient to leave the remainder.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_dstate)
            D_RECIP: begin
                if (r_sel == DIV_DAY) begin
                    mul_a = {1'b0, r_dvd[DIV_W-1:7]};
                end else begin
                    mul_a = r_dvd[MUL_W-1:0];
                end
                unique case (r_sel)
                    DIV_DAY:   mul_b = RCP_DAY;
                    DIV_PCT:   mul_b = RCP_PCT;
                    DIV_FULL:  mul_b = RCP_FULL;
                    DIV_THIRD: mul_b = RCP_THIRD;
                    default:   mul_b = '0;
                endcase
            end
            D_BACK: begin
                mul_a = {{(MUL_W-QUO_W){1'b0}}, quo_est};
                unique case (r_sel)
                    DIV_DAY:   mul_b = {9'd0, DAY_SECONDS};
                    DIV_PCT:   mul_b = {19'd0, PCT_MAX};
                    DIV_FULL:  mul_b = {18'd0, FULL_LEVEL};
                    DIV_THIRD: mul_b = 26'd3;
                    default:   mul_b = '0;
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Sequencing of the two multiply steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= D_IDLE;
            r_done   <= 1'b0;
        end else begin
            unique case (r_dstate)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_dstate <= D_RECIP;
                    end
                end
                D_RECIP: begin
                    r_dstate <= D_BACK;
                end
                D_BACK: begin
                    r_done   <= 1'b1;
                    r_dstate <= D_IDLE;
                end
                default: begin
                    r_dstate <= D_IDLE;
                end
            endcase
        end
    end

    // Operand capture, reciprocal product, quotient and remainder.
    always_ff @(posedge i_clk) begin
        if ((r_dstate == D_IDLE) && i_req.start) begin
            r_dvd <= i_req.dividend;
            r_sel <= i_req.divisor;
        end
        if (r_dstate == D_RECIP) begin
            r_prod <= product;
        end
        if (r_dstate == D_BACK) begin
            r_quo <= quo_est;
            r_rem <= DSOR_W'(r_dvd - product[DIV_W-1:0]);
        end
    end

    assign o_rsp.busy      = (r_dstate != D_IDLE);
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = {{(DIV_W-QUO_W){1'b0}}, r_quo};
    assign o_rsp.remainder = r_rem;

endmodule

/* sv/daylight_led_dimmer.sv */
// Top level of the daylight LED dimmer: sequencer, shared multiplier, shared divider and duty store.
//
//  Channel   Dir  Handshake     Carries
//  i_in      in   valid/ready   operation, channel, percent, epoch_seconds
//  o_out     out  valid/ready   four duty values and light_state
//
// A request that needs no curve goes straight to the hand-over; a button, a percent
// set and a tick in sync mode run the curve first. Each division by a fixed divisor
// goes through the shared reciprocal divider, used up to five times per request,
// and each multiply step through the shared multiplier.
// i_rst_n is synchronous; it clears the duty values, the mode, the step counters and
// the sequencer. A result waits in the output register while the next request is
// worked; the sequencer only stalls at the hand-over when a second result is ready
// before the first has been taken.
module daylight_led_dimmer (
    input  logic i_clk,
    input  logic i_rst_n,
    dld_in_if.sink    i_in,
    dld_out_if.source o_out
);
    import dld_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TICK_DIV,
        S_TICK_FOLD,
        S_TICK_MUL,
        S_SET_MUL,
        S_STEP_MUL,
        S_LVL_DIV,
        S_LVL_WAIT,
        S_SQ1,
        S_SQ1_DIV,
        S_SQ1_WAIT,
        S_SQ2,
        S_SQ2_DIV,
        S_SQ2_WAIT,
        S_C,
        S_C_HOLD,
        S_BLUE_MUL,
        S_RED_MUL,
        S_RED_DIV,
        S_RED_WAIT,
        S_WRITE,
        S_DONE
    } t_state;

    t_state      r_state;
    t_mode       r_mode;
    logic [7:0]  r_duty [4];
    logic [1:0]  r_rgb_step;
    logic [1:0]  r_white_step;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] r_epoch;
    logic [6:0]  r_pct;
    logic [1:0]  r_step;
    logic        r_is_tick;
    logic [3:0]  r_mask;
    logic [15:0] r_t;
    logic [25:0] r_acc;
    logic [7:0]  r_lvl;
    logic [7:0]  r_c;
    logic [7:0]  r_red;
    logic [7:0]  r_blue;

    logic [15:0] mul_a;
    logic [9:0]  mul_b;
    logic [25:0] product;
    logic [7:0]  excess;
    logic        over_quarter;
    logic [16:0] fold_t;
    logic        in_take;
    logic [1:0]  rgb_next;
    logic [1:0]  white_next;
    logic [6:0]  pct_sat;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    dld_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Handshake and small helpers.
    assign i_in.ready   = (r_state == S_IDLE);
    assign in_take      = i_in.valid && i_in.ready;
    assign rgb_next     = (r_rgb_step == 2'd3) ? 2'd0 : r_rgb_step + 2'd1;
    assign white_next   = (r_white_step == 2'd3) ? 2'd0 : r_white_step + 2'd1;
    assign pct_sat      = (i_in.payload.percent > PCT_MAX) ? PCT_MAX : i_in.payload.percent;
    assign over_quarter = (r_c >= QUARTER_LEVEL);
    assign excess       = over_quarter ? r_c - QUARTER_LEVEL : 8'd0;
    assign fold_t       = (div_rsp.remainder > HALF_DAY) ? DAY_SECONDS - div_rsp.remainder
                                                         : div_rsp.remainder;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_TICK_MUL: begin
                mul_a = r_t;
                mul_b = DAY_LEVEL_SCALE;
            end
            S_SET_MUL: begin
                mul_a = {9'd0, r_pct};
                mul_b = {2'd0, FULL_LEVEL};
            end
            S_STEP_MUL: begin
                mul_a = {14'd0, r_step};
                mul_b = STEP_LEVEL;
            end
            S_SQ1, S_SQ2: begin
                mul_a = {8'd0, r_lvl};
                mul_b = {2'd0, r_lvl};
            end
            S_C: begin
                mul_a = {8'd0, r_lvl};
                mul_b = 10'd3;
            end
            S_BLUE_MUL: begin
                mul_a = {8'd0, excess};
                mul_b = 10'd3;
            end
            S_RED_MUL: begin
                mul_a = {8'd0, excess};
                mul_b = 10'd2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Requests to the shared divider.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {6'd0, r_acc};
        div_req.divisor  = DIV_FULL;
        unique case (r_state)
            S_TICK_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_epoch;
                div_req.divisor  = DIV_DAY;
            end
            S_LVL_DIV: begin
                div_req.start = 1'b1;
                if (r_is_tick) begin
                    div_req.divisor = DIV_DAY;
                end else begin
                    div_req.divisor = DIV_PCT;
                end
            end
            S_SQ1_DIV, S_SQ2_DIV: begin
                div_req.start = 1'b1;
            end
            S_RED_DIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_THIRD;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer, state of the dimmer and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_SYNC;
            r_rgb_step   <= 2'd0;
            r_white_step <= 2'd0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= 8'd0;
            end
        end else begin
            // A taken result frees the register unless a new one replaces it now.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_epoch   <= i_in.payload.epoch_seconds;
                        r_pct     <= pct_sat;
                        r_is_tick <= (i_in.payload.operation == OP_TICK);
                        unique case (i_in.payload.operation)
                            OP_TICK: begin
                                r_mask <= 4'b1111;
                                if (r_mode == MODE_SYNC) begin
                                    r_state <= S_TICK_DIV;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_SET: begin
                                r_mode  <= MODE_CMD;
                                r_mask  <= 4'b0001 << i_in.payload.channel;
                                r_state <= S_SET_MUL;
                            end
                            OP_CLEAR: begin
                                r_mode  <= MODE_CMD;
                                r_state <= S_DONE;
                                for (int i = 0; i < 4; i++) begin
                                    r_duty[i] <= 8'd0;
                                end
                            end
                            OP_RGB: begin
                                r_mode     <= MODE_CMD;
                                r_rgb_step <= rgb_next;
                                r_step     <= rgb_next;
                                r_mask     <= 4'b0111;
                                r_state    <= S_STEP_MUL;
                            end
                            OP_WHITE: begin
                                r_mode       <= MODE_CMD;
                                r_white_step <= white_next;
                                r_step       <= white_next;
                                r_mask       <= 4'b1000;
                                r_state      <= S_STEP_MUL;
                            end
                            OP_SYNC: begin
                                r_mode  <= MODE_SYNC;
                                r_state <= S_DONE;
                            end
                            OP_HOLD: begin
                                r_mode  <= MODE_HOLD;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_TICK_DIV: begin
                    r_state <= S_TICK_FOLD;
                end
                S_TICK_FOLD: begin
                    // Seconds of the day, folded into a triangle peaking at noon.
                    if (div_rsp.done) begin
                        r_t     <= fold_t[15:0];
                        r_state <= S_TICK_MUL;
                    end
                end
                S_TICK_MUL: begin
                    r_acc   <= product;
                    r_state <= S_LVL_DIV;
                end
                S_SET_MUL: begin
                    r_acc   <= product;
                    r_state <= S_LVL_DIV;
                end
                S_STEP_MUL: begin
                    r_lvl   <= product[7:0];
                    r_state <= S_SQ1;
                end
                S_LVL_DIV: begin
                    r_state <= S_LVL_WAIT;
                end
                S_LVL_WAIT: begin
                    if (div_rsp.done) begin
                        r_lvl   <= div_rsp.quotient[7:0];
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: begin
                    r_acc   <= product;
                    r_state <= S_SQ1_DIV;
                end
                S_SQ1_DIV: begin
                    r_state <= S_SQ1_WAIT;
                end
                S_SQ1_WAIT: begin
                    if (div_rsp.done) begin
                        r_lvl   <= div_rsp.quotient[7:0];
                        r_state <= S_SQ2;
                    end
                end
                S_SQ2: begin
                    r_acc   <= product;
                    r_state <= S_SQ2_DIV;
                end
                S_SQ2_DIV: begin
                    r_state <= S_SQ2_WAIT;
                end
                S_SQ2_WAIT: begin
                    if (div_rsp.done) begin
                        r_lvl   <= div_rsp.quotient[7:0];
                        r_state <= S_C;
                    end
                end
                S_C: begin
                    r_acc   <= product;
                    r_state <= S_C_HOLD;
                end
                S_C_HOLD: begin
                    // Three quarters of the curve after both squarings.
                    r_c     <= r_acc[9:2];
                    r_state <= S_BLUE_MUL;
                end
                S_BLUE_MUL: begin
                    r_acc   <= product;
                    r_state <= S_RED_MUL;
                end
                S_RED_MUL: begin
                    r_blue  <= over_quarter ? r_acc[9:2] + QUARTER_LEVEL : r_c;
                    r_acc   <= product;
                    r_state <= S_RED_DIV;
                end
                S_RED_DIV: begin
                    r_state <= S_RED_WAIT;
                end
                S_RED_WAIT: begin
                    if (div_rsp.done) begin
                        r_red   <= over_quarter ? div_rsp.quotient[7:0] + QUARTER_LEVEL : r_c;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_mask[CH_RED]) begin
                        r_duty[CH_RED] <= r_red;
                    end
                    if (r_mask[CH_GREEN]) begin
                        r_duty[CH_GREEN] <= r_c;
                    end
                    if (r_mask[CH_BLUE]) begin
                        r_duty[CH_BLUE] <= r_blue;
                    end
                    if (r_mask[CH_WHITE]) begin
                        r_duty[CH_WHITE] <= r_c;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hand the state over once the output register is free.
                    if (!r_out_valid || o_out.ready) begin
                        r_out.duty_red    <= r_duty[CH_RED];
                        r_out.duty_green  <= r_duty[CH_GREEN];
                        r_out.duty_blue   <= r_duty[CH_BLUE];
                        r_out.duty_white  <= r_duty[CH_WHITE];
                        r_out.light_state <= r_mode;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !i_in.ready)
        else $error("input taken while a request was still being worked");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the hand-over state");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.duty_red <= DUTY_MAX) && (r_out.duty_green <= DUTY_MAX)
                        && (r_out.duty_blue <= DUTY_MAX) && (r_out.duty_white <= DUTY_MAX))
        else $error("duty value beyond the curve range");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule
